// ----- rtl/obd_pkg.sv -----
// Shared types, register indexes and the Bayer table of the ordered dither bias block.
`timescale 1ns / 1ps
package obd_pkg;

   // Input word: three channel values and the amplitude of the pixel's block (Q2.8).
   typedef struct packed {
      logic [7:0] chan_zero;
      logic [7:0] chan_one;
      logic [7:0] chan_two;
      logic [9:0] block_amplitude;
   } obd_req_type;

   // Result word: three channel values after bias, rounding and clamping.
   typedef struct packed {
      logic [7:0] out_zero;
      logic [7:0] out_one;
      logic [7:0] out_two;
   } obd_rsp_type;

   // Programmed registers as one group.
   typedef struct packed {
      logic [15:0] level_step;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [12:0] block_width;
      logic [12:0] block_height;
      logic [2:0]  channel_count;
   } obd_cfg_type;

   // A classified pixel as it waits between the front and the back.
   typedef struct packed {
      obd_req_type        pixel;
      logic signed [4:0]  bias_weight;
      logic               color;
   } obd_task_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SIZE_W      = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_STEP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_HEIGHT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd5;

   localparam logic [15:0] RESET_LEVEL_STEP    = 16'd65280;
   localparam logic [12:0] RESET_FRAME_WIDTH   = 13'd640;
   localparam logic [12:0] RESET_FRAME_HEIGHT  = 13'd480;
   localparam logic [12:0] RESET_BLOCK_WIDTH   = 13'd8;
   localparam logic [12:0] RESET_BLOCK_HEIGHT  = 13'd8;
   localparam logic [2:0]  RESET_CHANNEL_COUNT = 3'd3;

   // Color mode biases all three channels from this channel count upward.
   localparam logic [2:0] COLOR_MIN_CHANNELS = 3'd3;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] BAYER [4][4] = '{
      '{4'd0,  4'd8,  4'd2,  4'd10},
      '{4'd12, 4'd4,  4'd14, 4'd6},
      '{4'd3,  4'd11, 4'd1,  4'd9},
      '{4'd15, 4'd7,  4'd13, 4'd5}
   };

   // Bayer entry minus eight, the signed weight of the bias in sixteenths.
   function automatic logic signed [4:0] bayer_weight(input logic [1:0] row,
                                                      input logic [1:0] col);
      logic signed [4:0] entry;
      entry = signed'({1'b0, BAYER[row][col]});
      return entry - 5'sd8;
   endfunction

endpackage

// ----- rtl/obd_front.sv -----
// Front end: takes pixel words, tracks raster and block position, picks the Bayer weight.
`timescale 1ns / 1ps
module obd_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  obd_pkg::obd_req_type req_data,
   input  obd_pkg::obd_cfg_type cfg,
   output logic                 push_valid,
   output obd_pkg::obd_task_type push_data,
   input  logic                 push_full
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int BW = obd_pkg::SIZE_W;

   logic [CW-1:0] column_count_ff, column_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;
   logic [BW-1:0] in_block_column_ff, in_block_column_in;
   logic [BW-1:0] in_block_row_ff, in_block_row_in;
   logic [1:0]    block_column_mod4_ff, block_column_mod4_in;
   logic [1:0]    block_row_mod4_ff, block_row_mod4_in;

   logic          accept;
   logic [31:0]   eff_fw, eff_fh;
   logic [BW:0]   eff_bw, eff_bh;
   logic [CW:0]   col_next;
   logic [RW:0]   row_next;
   logic [BW:0]   ibc_next, ibr_next;

   assign req_stall = push_full;
   assign accept    = req_valid && !push_full;

   assign push_valid            = accept;
   assign push_data.pixel       = req_data;
   assign push_data.bias_weight = obd_pkg::bayer_weight(block_row_mod4_ff,
                                                        block_column_mod4_ff);
   assign push_data.color       = (cfg.channel_count >= obd_pkg::COLOR_MIN_CHANNELS);

   // A size of zero acts as one; frame sizes are capped at the maximum.
   always_comb begin
      if (cfg.frame_width == '0) begin
         eff_fw = 32'd1;
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         eff_fw = 32'(MAX_WIDTH);
      end else begin
         eff_fw = 32'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         eff_fh = 32'd1;
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         eff_fh = 32'(MAX_HEIGHT);
      end else begin
         eff_fh = 32'(cfg.frame_height);
      end
      eff_bw = (cfg.block_width == '0)  ? (BW+1)'(1) : {1'b0, cfg.block_width};
      eff_bh = (cfg.block_height == '0) ? (BW+1)'(1) : {1'b0, cfg.block_height};
   end

   always_comb begin
      column_count_in      = column_count_ff;
      row_count_in         = row_count_ff;
      in_block_column_in   = in_block_column_ff;
      in_block_row_in      = in_block_row_ff;
      block_column_mod4_in = block_column_mod4_ff;
      block_row_mod4_in    = block_row_mod4_ff;
      col_next = {1'b0, column_count_ff} + (CW+1)'(1);
      row_next = {1'b0, row_count_ff} + (RW+1)'(1);
      ibc_next = {1'b0, in_block_column_ff} + (BW+1)'(1);
      ibr_next = {1'b0, in_block_row_ff} + (BW+1)'(1);
      if (accept) begin
         column_count_in    = col_next[CW-1:0];
         in_block_column_in = ibc_next[BW-1:0];
         if (ibc_next >= eff_bw) begin
            in_block_column_in   = '0;
            block_column_mod4_in = block_column_mod4_ff + 2'd1;
         end
         if (32'(col_next) >= eff_fw) begin
            column_count_in      = '0;
            in_block_column_in   = '0;
            block_column_mod4_in = '0;
            row_count_in         = row_next[RW-1:0];
            in_block_row_in      = ibr_next[BW-1:0];
            if (ibr_next >= eff_bh) begin
               in_block_row_in   = '0;
               block_row_mod4_in = block_row_mod4_ff + 2'd1;
            end
            if (32'(row_next) >= eff_fh) begin
               row_count_in      = '0;
               in_block_row_in   = '0;
               block_row_mod4_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff      <= '0;
         row_count_ff         <= '0;
         in_block_column_ff   <= '0;
         in_block_row_ff      <= '0;
         block_column_mod4_ff <= '0;
         block_row_mod4_ff    <= '0;
      end else begin
         column_count_ff      <= column_count_in;
         row_count_ff         <= row_count_in;
         in_block_column_ff   <= in_block_column_in;
         in_block_row_ff      <= in_block_row_in;
         block_column_mod4_ff <= block_column_mod4_in;
         block_row_mod4_ff    <= block_row_mod4_in;
      end
   end

endmodule

// ----- rtl/obd_queue.sv -----
// Short queue of classified pixels between the front and the back.
`timescale 1ns / 1ps
module obd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  obd_pkg::obd_task_type push_data,
   output logic                  push_full,
   input  logic                  pop_ready,
   output logic                  pop_valid,
   output obd_pkg::obd_task_type pop_data
);

   localparam int DEPTH = obd_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   obd_pkg::obd_task_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_full = (count_ff == NW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/obd_back.sv -----
// Back end: scales the bias, adds it to the channels, rounds, clamps and holds the result.
`timescale 1ns / 1ps
module obd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           level_step,
   input  logic                  pop_valid,
   input  obd_pkg::obd_task_type pop_data,
   output logic                  pop_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output obd_pkg::obd_rsp_type  rsp_data
);

   logic                  advance;
   logic                  s1_valid_ff, s1_valid_in;
   obd_pkg::obd_task_type s1_task_ff, s1_task_in;
   logic [25:0]           s1_mag_ff, s1_mag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   obd_pkg::obd_rsp_type  rsp_data_ff, rsp_data_in;
   logic signed [31:0]    bias;

   // Channel plus bias (20 fraction bits), half away from zero, clamped to 0..255.
   // A negative sum always ends at zero, so only the positive side rounds.
   function automatic logic [7:0] round_clamp(input logic [7:0] chan,
                                              input logic signed [31:0] prod);
      logic signed [31:0] sum;
      logic signed [31:0] rounded;
      logic [11:0]        whole;
      logic [7:0]         res;
      sum     = signed'({4'b0, chan, 20'b0}) + prod;
      rounded = sum + 32'sd524288;
      whole   = rounded[31:20];
      if (sum[31]) begin
         res = 8'd0;
      end else if (whole > 12'd255) begin
         res = 8'd255;
      end else begin
         res = whole[7:0];
      end
      return res;
   endfunction

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bias = 32'(s1_task_ff.bias_weight) * signed'(32'(s1_mag_ff));

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_task_in   = s1_task_ff;
      s1_mag_in    = s1_mag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         s1_valid_in  = pop_valid;
         s1_task_in   = pop_data;
         s1_mag_in    = 26'(level_step) * 26'(pop_data.pixel.block_amplitude);
         rsp_valid_in = s1_valid_ff;
         rsp_data_in.out_zero = round_clamp(s1_task_ff.pixel.chan_zero, bias);
         if (s1_task_ff.color) begin
            rsp_data_in.out_one = round_clamp(s1_task_ff.pixel.chan_one, bias);
            rsp_data_in.out_two = round_clamp(s1_task_ff.pixel.chan_two, bias);
         end else begin
            rsp_data_in.out_one = s1_task_ff.pixel.chan_one;
            rsp_data_in.out_two = s1_task_ff.pixel.chan_two;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_task_ff  <= s1_task_in;
      s1_mag_ff   <= s1_mag_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/block_ordered_dither_bias_core.sv -----
// Top level of the ordered 4x4 Bayer dither bias block.
`timescale 1ns / 1ps
// The core takes one pixel word per clock in raster order (up to three 8-bit
// channels and the Q2.8 contrast amplitude of its block) and returns one word
// per pixel with the channels offset by (entry - 8) / 16 * level_step * amplitude,
// where entry is the 4x4 Bayer value chosen by the block column and block row
// modulo four. Sums are rounded half away from zero and clamped to 0..255; an
// amplitude of zero passes the pixel through, and with fewer than three
// channels only the first channel is biased. The front end accepts a word, keeps
// the raster and block counters and picks the weight; a two-entry queue carries
// the word to the back end, which forms level_step * amplitude in its first
// stage and applies the weighted bias in its second, ending in an output
// register. Sustained rate is one word per clock: the back end moves whenever
// its output register is empty or being read, so the input stalls only once the
// queue has filled behind a held result word. A word's result passes the queue
// slot, the multiply stage and the output register before it is offered, and
// it is taken at an edge on which the result side does not stall. Program
// registers only with no words in flight; counters keep their values across
// a write and wrap at the next pixel if they sit beyond a new limit. Frame
// sizes larger than MAX_WIDTH or MAX_HEIGHT act as the maximum, and a size of
// zero acts as one.
module block_ordered_dither_bias_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  obd_pkg::obd_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output obd_pkg::obd_rsp_type                 rsp_data,
   input  logic                                 csr_wen,
   input  logic [obd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [obd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   obd_pkg::obd_cfg_type  cfg_ff, cfg_in;
   logic                  push_valid;
   obd_pkg::obd_task_type push_data;
   logic                  push_full;
   logic                  pop_valid;
   obd_pkg::obd_task_type pop_data;
   logic                  pop_ready;

   // Register writes; each register keeps only the bits it holds.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            obd_pkg::CSR_LEVEL_STEP:    cfg_in.level_step    = csr_wdata;
            obd_pkg::CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_wdata[12:0];
            obd_pkg::CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wdata[12:0];
            obd_pkg::CSR_BLOCK_WIDTH:   cfg_in.block_width   = csr_wdata[12:0];
            obd_pkg::CSR_BLOCK_HEIGHT:  cfg_in.block_height  = csr_wdata[12:0];
            obd_pkg::CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_wdata[2:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_step    <= obd_pkg::RESET_LEVEL_STEP;
         cfg_ff.frame_width   <= obd_pkg::RESET_FRAME_WIDTH;
         cfg_ff.frame_height  <= obd_pkg::RESET_FRAME_HEIGHT;
         cfg_ff.block_width   <= obd_pkg::RESET_BLOCK_WIDTH;
         cfg_ff.block_height  <= obd_pkg::RESET_BLOCK_HEIGHT;
         cfg_ff.channel_count <= obd_pkg::RESET_CHANNEL_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   obd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (push_full)
   );

   obd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (push_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   obd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .level_step (cfg_ff.level_step),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/obd_port_checker.sv -----
// Port-level checks of the dither bias core, bound to its top level.
`timescale 1ns / 1ps
module obd_port_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input obd_pkg::obd_rsp_type rsp_data
);

   // A stalled result word stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // Reset empties the result side.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word offered right after reset");

   // The queue can only fill while a result word is held back.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no result word waiting");

   // Once the result side drains and stays open, the input side opens.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall && $past(!rsp_stall) && !$past(reset) |-> !req_stall)
      else $error("input stalled although results flowed freely");

endmodule

bind block_ordered_dither_bias_core obd_port_checker u_obd_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
